// File: hw/rtl/id_table_name_lookup_stream_core_assert.svh
// Assertion macros used by the id table lookup checker.
`ifndef ID_TABLE_NAME_LOOKUP_STREAM_CORE_ASSERT_SVH
`define ID_TABLE_NAME_LOOKUP_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IDTNL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("id table lookup check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IDTNL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("id table lookup check failed");

`endif

// File: hw/rtl/idtnl_pkg.sv
// Types, codes and constants of the id table name lookup stream.
package idtnl_pkg;

  localparam int ID_DIGITS_DEFAULT = 4;
  localparam int CFG_ADDR_W        = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int ID_W              = 16;

  // Register indexes
  localparam logic REG_VENDOR_ID  = 1'b0;
  localparam logic REG_PRODUCT_ID = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_VENDOR_CHAR  = 2'd0;
  localparam logic [1:0] KIND_PRODUCT_CHAR = 2'd1;
  localparam logic [1:0] KIND_FINISHED     = 2'd2;

  // Finish status codes
  localparam logic [1:0] STATUS_BOTH_FOUND  = 2'd0;
  localparam logic [1:0] STATUS_VENDOR_ONLY = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND   = 2'd2;

  // Line kinds
  localparam logic [1:0] LINE_VENDOR    = 2'd0;
  localparam logic [1:0] LINE_PRODUCT   = 2'd1;
  localparam logic [1:0] LINE_INTERFACE = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] name_char;
    logic [1:0] status;
  } result_t;

endpackage

// File: hw/rtl/id_table_name_lookup_stream_core.sv
// Id table name lookup: parses a streamed text table and emits matched names.
//
// Usage:
//   Table bytes arrive on the item channel (valid/ready), one request per
//   character; a request with end_of_file set closes the table and rearms
//   the search. Vendor and product ids are set over the APB port (vendor_id
//   at 0x0, product_id at 0x4) while the block is idle.
//   Each request yields zero or one result: a vendor name character, a
//   product name character, or one final status per search.
//   A result is registered in the result register, or in the skid register
//   while one waits. Throughput: one request per cycle while item_ready
//   is high; a byte is a single state update, item port to result register.
//   A two-deep output (result register plus skid register) keeps item_ready
//   high while one result waits; item_ready drops only when both hold data.
//   Reset (rst, synchronous) empties the output and puts the parser at the
//   start of a line, looking for the vendor; both ids reset to zero.
module id_table_name_lookup_stream_core #(
  parameter int ID_DIGITS = idtnl_pkg::ID_DIGITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // table bytes
  input  logic                              item_valid,
  output logic                              item_ready,
  input  idtnl_pkg::item_t                  item,
  // lookup results
  output logic                              result_valid,
  input  logic                              result_ready,
  output idtnl_pkg::result_t                result,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [idtnl_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [idtnl_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [idtnl_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int ACC_W = 4 * ID_DIGITS;
  localparam int CNT_W = $clog2(ID_DIGITS + 1);
  localparam int CMP_W = (ACC_W > idtnl_pkg::ID_W) ? ACC_W : idtnl_pkg::ID_W;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_AFTER_TAB,
    PH_DIGITS,
    PH_SKIP,
    PH_LEAD_WS,
    PH_NAME,
    PH_DONE
  } phase_t;

  // Configuration registers
  logic [idtnl_pkg::ID_W-1:0] vendor_id;
  logic [idtnl_pkg::ID_W-1:0] product_id;

  // Parser state
  phase_t           phase, phase_next;
  logic [ACC_W-1:0] id_acc, id_acc_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  logic [1:0]       line_kind, line_kind_next;
  logic             vendor_found, vendor_found_next;

  // Output stage
  idtnl_pkg::result_t skid;
  logic               skid_valid;
  idtnl_pkg::result_t res;
  logic               res_produce;

  logic accept;
  logic take;
  logic push;

  // Digit path
  logic [1:0]       dig_kind;
  logic [ACC_W-1:0] dig_acc_base;
  logic [CNT_W-1:0] dig_cnt_base;
  logic             dig_run;
  logic             dig_is_hex;
  logic [3:0]       dig_val;
  logic [ACC_W-1:0] dig_acc;
  logic [CNT_W-1:0] dig_cnt;
  logic [CMP_W-1:0] dig_id;
  logic [1:0]       miss_status;

  logic [7:0] c;

  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= "0" && ch <= "9") begin
      r = {1'b1, 4'(ch - "0")};
    end else if (ch >= "a" && ch <= "f") begin
      r = {1'b1, 4'(ch - "a" + 8'd10)};
    end else if (ch >= "A" && ch <= "F") begin
      r = {1'b1, 4'(ch - "A" + 8'd10)};
    end
    return r;
  endfunction

  assign c          = item.byte_value;
  assign item_ready = !skid_valid;
  assign accept     = item_valid && item_ready;
  assign take       = result_valid && result_ready;
  assign push       = accept && res_produce;
  assign miss_status = vendor_found ? idtnl_pkg::STATUS_VENDOR_ONLY
                                    : idtnl_pkg::STATUS_NOT_FOUND;

  // APB: always ready, writes land on the access cycle
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      idtnl_pkg::REG_VENDOR_ID:  prdata = idtnl_pkg::CFG_DATA_W'(vendor_id);
      idtnl_pkg::REG_PRODUCT_ID: prdata = idtnl_pkg::CFG_DATA_W'(product_id);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vendor_id  <= '0;
      product_id <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == idtnl_pkg::REG_VENDOR_ID) begin
        vendor_id <= pwdata[idtnl_pkg::ID_W-1:0];
      end else begin
        product_id <= pwdata[idtnl_pkg::ID_W-1:0];
      end
    end
  end

  // Digit accumulation; base values depend on whether this byte opens the id
  always_comb begin
    logic [4:0] h;
    h = hex_decode(c);
    dig_is_hex = h[4];
    dig_val    = h[3:0];
    dig_acc    = {dig_acc_base[ACC_W-5:0], dig_val};
    dig_cnt    = dig_cnt_base + CNT_W'(1);
    dig_id     = CMP_W'(dig_acc);
  end

  // Per-byte parser step
  always_comb begin
    phase_next        = phase;
    id_acc_next       = id_acc;
    digit_count_next  = digit_count;
    line_kind_next    = line_kind;
    vendor_found_next = vendor_found;
    res_produce       = 1'b0;
    res               = '0;
    dig_run           = 1'b0;
    dig_kind          = line_kind;
    dig_acc_base      = id_acc;
    dig_cnt_base      = digit_count;

    if (item.end_of_file) begin
      // end of table: close an open search, then rearm
      if (phase != PH_DONE) begin
        res_produce = 1'b1;
        res.kind    = idtnl_pkg::KIND_FINISHED;
        res.status  = (phase == PH_NAME && line_kind == idtnl_pkg::LINE_PRODUCT)
                      ? idtnl_pkg::STATUS_BOTH_FOUND : miss_status;
      end
      phase_next        = PH_LINE_START;
      id_acc_next       = '0;
      digit_count_next  = '0;
      line_kind_next    = idtnl_pkg::LINE_VENDOR;
      vendor_found_next = 1'b0;
    end else begin
      case (phase)
        PH_LINE_START: begin
          if (c == idtnl_pkg::CH_HASH) begin
            phase_next = PH_SKIP;
          end else if (c == idtnl_pkg::CH_TAB) begin
            phase_next = PH_AFTER_TAB;
          end else if (c != idtnl_pkg::CH_NEWLINE) begin
            dig_run      = 1'b1;
            dig_kind     = idtnl_pkg::LINE_VENDOR;
            dig_acc_base = '0;
            dig_cnt_base = '0;
          end
        end
        PH_AFTER_TAB: begin
          if (c == idtnl_pkg::CH_TAB) begin
            line_kind_next   = idtnl_pkg::LINE_INTERFACE;
            id_acc_next      = '0;
            digit_count_next = '0;
            phase_next       = PH_DIGITS;
          end else begin
            dig_run      = 1'b1;
            dig_kind     = idtnl_pkg::LINE_PRODUCT;
            dig_acc_base = '0;
            dig_cnt_base = '0;
          end
        end
        PH_DIGITS: begin
          dig_run = 1'b1;
        end
        PH_SKIP: begin
          if (c == idtnl_pkg::CH_NEWLINE) begin
            phase_next = PH_LINE_START;
          end
        end
        PH_LEAD_WS: begin
          if (c == idtnl_pkg::CH_NEWLINE) begin
            // empty name
            res_produce = 1'b1;
            res.kind    = idtnl_pkg::KIND_FINISHED;
            res.status  = miss_status;
            phase_next  = PH_DONE;
          end else if (c != idtnl_pkg::CH_SPACE && c != idtnl_pkg::CH_TAB) begin
            phase_next = PH_NAME;
            if (line_kind == idtnl_pkg::LINE_VENDOR) begin
              vendor_found_next = 1'b1;
            end
            res_produce   = 1'b1;
            res.kind      = (line_kind == idtnl_pkg::LINE_VENDOR)
                            ? idtnl_pkg::KIND_VENDOR_CHAR : idtnl_pkg::KIND_PRODUCT_CHAR;
            res.name_char = c;
          end
        end
        PH_NAME: begin
          if (c == idtnl_pkg::CH_NEWLINE) begin
            if (line_kind == idtnl_pkg::LINE_VENDOR) begin
              phase_next = PH_LINE_START;
            end else begin
              res_produce = 1'b1;
              res.kind    = idtnl_pkg::KIND_FINISHED;
              res.status  = idtnl_pkg::STATUS_BOTH_FOUND;
              phase_next  = PH_DONE;
            end
          end else begin
            res_produce   = 1'b1;
            res.kind      = (line_kind == idtnl_pkg::LINE_VENDOR)
                            ? idtnl_pkg::KIND_VENDOR_CHAR : idtnl_pkg::KIND_PRODUCT_CHAR;
            res.name_char = c;
          end
        end
        default: begin
          // finished: bytes are dropped until end of table
        end
      endcase

      // id digit and line decision
      if (dig_run) begin
        line_kind_next   = dig_kind;
        id_acc_next      = dig_acc;
        digit_count_next = dig_cnt;
        if (!dig_is_hex) begin
          res_produce = 1'b1;
          res.kind    = idtnl_pkg::KIND_FINISHED;
          res.status  = miss_status;
          phase_next  = PH_DONE;
        end else if (dig_cnt < CNT_W'(ID_DIGITS)) begin
          phase_next = PH_DIGITS;
        end else if (!vendor_found) begin
          if (dig_kind != idtnl_pkg::LINE_VENDOR) begin
            phase_next = PH_SKIP;
          end else if (dig_id > CMP_W'(vendor_id)) begin
            res_produce = 1'b1;
            res.kind    = idtnl_pkg::KIND_FINISHED;
            res.status  = idtnl_pkg::STATUS_NOT_FOUND;
            phase_next  = PH_DONE;
          end else begin
            phase_next = (dig_id == CMP_W'(vendor_id)) ? PH_LEAD_WS : PH_SKIP;
          end
        end else begin
          if (dig_kind == idtnl_pkg::LINE_INTERFACE) begin
            phase_next = PH_SKIP;
          end else if (dig_kind == idtnl_pkg::LINE_VENDOR ||
                       dig_id > CMP_W'(product_id)) begin
            res_produce = 1'b1;
            res.kind    = idtnl_pkg::KIND_FINISHED;
            res.status  = idtnl_pkg::STATUS_VENDOR_ONLY;
            phase_next  = PH_DONE;
          end else begin
            phase_next = (dig_id == CMP_W'(product_id)) ? PH_LEAD_WS : PH_SKIP;
          end
        end
      end
    end
  end

  // State, result register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LINE_START;
      id_acc       <= '0;
      digit_count  <= '0;
      line_kind    <= idtnl_pkg::LINE_VENDOR;
      vendor_found <= 1'b0;
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        id_acc       <= id_acc_next;
        digit_count  <= digit_count_next;
        line_kind    <= line_kind_next;
        vendor_found <= vendor_found_next;
      end
      if (take) begin
        if (skid_valid) begin
          result     <= skid;
          skid_valid <= 1'b0;
        end else begin
          result_valid <= push;
          result       <= res;
        end
      end else if (!result_valid) begin
        result_valid <= push;
        result       <= res;
      end else if (push) begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/idtnl_checker.sv
// Port-level checker for the id table lookup core, with its bind.
`include "id_table_name_lookup_stream_core_assert.svh"

module idtnl_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input idtnl_pkg::result_t result
);

  // a stalled result holds until taken
  `IDTNL_ASSERT_NXT(a_result_hold, result_valid && !result_ready,
                    result_valid && $stable(result))

  // input backpressure only while a result is waiting
  `IDTNL_ASSERT_IMP(a_ready_only_on_stall, !item_ready, result_valid)

  // finish results carry no character
  `IDTNL_ASSERT_IMP(a_finish_fields,
                    result_valid && result.kind == idtnl_pkg::KIND_FINISHED,
                    result.name_char == 8'd0 &&
                    result.status != 2'd3)

  // name character results carry a zero status
  `IDTNL_ASSERT_IMP(a_char_fields,
                    result_valid && result.kind != idtnl_pkg::KIND_FINISHED,
                    result.status == idtnl_pkg::STATUS_BOTH_FOUND &&
                    result.kind != 2'd3)

endmodule

bind id_table_name_lookup_stream_core idtnl_checker u_idtnl_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// File: tb/sv/name_lookup_checker.sv
// Checker for the id table name lookup: tracks the table parse and compares each result.
`timescale 1ns / 1ps

module name_lookup_checker #(
  parameter int ID_DIGITS = idtnl_pkg::ID_DIGITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  input  logic                             item_ready,
  input  idtnl_pkg::item_t                 item,
  input  logic                             result_valid,
  input  logic                             result_ready,
  input  idtnl_pkg::result_t               result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [idtnl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [idtnl_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                             pready,
  output int                               error_count,
  output int                               pending_count
);

  localparam logic [idtnl_pkg::CFG_ADDR_W-1:0] VENDOR_ADDR  =
    {idtnl_pkg::REG_VENDOR_ID, 2'b00};
  localparam logic [idtnl_pkg::CFG_ADDR_W-1:0] PRODUCT_ADDR =
    {idtnl_pkg::REG_PRODUCT_ID, 2'b00};

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  typedef enum logic [2:0] {
    SCAN_LINE_START,
    SCAN_AFTER_TAB,
    SCAN_DIGITS,
    SCAN_SKIP,
    SCAN_LEAD_WS,
    SCAN_NAME,
    SCAN_DONE
  } scan_phase_t;

  // parser copy and register copy
  scan_phase_t                scan_phase;
  logic [31:0]                id_acc;
  int                         digits_seen;
  logic [1:0]                 line_type;
  logic                       vendor_hit;
  logic                       search_done;
  logic [idtnl_pkg::ID_W-1:0] want_vendor;
  logic [idtnl_pkg::ID_W-1:0] want_product;

  idtnl_pkg::result_t pending_name_results[$];
  int                 mismatches;

  assign error_count = mismatches;

  initial mismatches = 0;

  function automatic void clear_scan();
    scan_phase  = SCAN_LINE_START;
    id_acc      = '0;
    digits_seen = 0;
    line_type   = idtnl_pkg::LINE_VENDOR;
    vendor_hit  = 1'b0;
    search_done = 1'b0;
  endfunction

  function automatic logic [1:0] miss_status();
    return vendor_hit ? idtnl_pkg::STATUS_VENDOR_ONLY : idtnl_pkg::STATUS_NOT_FOUND;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic bit finish_search(input logic [1:0] st,
                                       output idtnl_pkg::result_t res);
    search_done = 1'b1;
    scan_phase  = SCAN_DONE;
    res = '{kind: idtnl_pkg::KIND_FINISHED, name_char: 8'h00, status: st};
    return 1'b1;
  endfunction

  // one id digit; the last digit decides what happens to the line
  function automatic bit take_digit(input logic [7:0] c, output idtnl_pkg::result_t res);
    int d;
    d   = hex_digit(c);
    res = '0;
    if (d < 0) return finish_search(miss_status(), res);
    id_acc = (id_acc << 4) | 32'(d);
    digits_seen++;
    if (digits_seen < ID_DIGITS) begin
      scan_phase = SCAN_DIGITS;
      return 1'b0;
    end
    if (!vendor_hit) begin
      if (line_type != idtnl_pkg::LINE_VENDOR) begin
        scan_phase = SCAN_SKIP;
        return 1'b0;
      end
      if (id_acc > 32'(want_vendor)) return finish_search(idtnl_pkg::STATUS_NOT_FOUND, res);
      scan_phase = (id_acc == 32'(want_vendor)) ? SCAN_LEAD_WS : SCAN_SKIP;
      return 1'b0;
    end
    if (line_type == idtnl_pkg::LINE_INTERFACE) begin
      scan_phase = SCAN_SKIP;
      return 1'b0;
    end
    // next vendor line or a larger product id ends the product search
    if (line_type == idtnl_pkg::LINE_VENDOR)
      return finish_search(idtnl_pkg::STATUS_VENDOR_ONLY, res);
    if (id_acc > 32'(want_product))
      return finish_search(idtnl_pkg::STATUS_VENDOR_ONLY, res);
    scan_phase = (id_acc == 32'(want_product)) ? SCAN_LEAD_WS : SCAN_SKIP;
    return 1'b0;
  endfunction

  function automatic void start_id(input logic [1:0] kind);
    line_type   = kind;
    id_acc      = '0;
    digits_seen = 0;
  endfunction

  function automatic logic [1:0] char_kind();
    return (line_type == idtnl_pkg::LINE_VENDOR) ? idtnl_pkg::KIND_VENDOR_CHAR
                                                 : idtnl_pkg::KIND_PRODUCT_CHAR;
  endfunction

  // advance the parse by one table byte; returns 1 when a result is due
  function automatic bit scan_table_byte(input idtnl_pkg::item_t it,
                                         output idtnl_pkg::result_t res);
    logic [7:0] c;
    logic [1:0] st;
    c   = it.byte_value;
    res = '0;
    if (it.end_of_file) begin
      if (!search_done) begin
        st = (scan_phase == SCAN_NAME && line_type == idtnl_pkg::LINE_PRODUCT) ?
             idtnl_pkg::STATUS_BOTH_FOUND : miss_status();
        res = '{kind: idtnl_pkg::KIND_FINISHED, name_char: 8'h00, status: st};
        clear_scan();
        return 1'b1;
      end
      clear_scan();
      return 1'b0;
    end
    if (search_done) return 1'b0;
    case (scan_phase)
      SCAN_LINE_START: begin
        if (c == idtnl_pkg::CH_HASH) begin
          scan_phase = SCAN_SKIP;
          return 1'b0;
        end
        if (c == idtnl_pkg::CH_NEWLINE) return 1'b0;
        if (c == idtnl_pkg::CH_TAB) begin
          scan_phase = SCAN_AFTER_TAB;
          return 1'b0;
        end
        start_id(idtnl_pkg::LINE_VENDOR);
        return take_digit(c, res);
      end
      SCAN_AFTER_TAB: begin
        if (c == idtnl_pkg::CH_TAB) begin
          start_id(idtnl_pkg::LINE_INTERFACE);
          scan_phase = SCAN_DIGITS;
          return 1'b0;
        end
        start_id(idtnl_pkg::LINE_PRODUCT);
        return take_digit(c, res);
      end
      SCAN_DIGITS: return take_digit(c, res);
      SCAN_SKIP: begin
        if (c == idtnl_pkg::CH_NEWLINE) scan_phase = SCAN_LINE_START;
        return 1'b0;
      end
      SCAN_LEAD_WS: begin
        if (c == idtnl_pkg::CH_SPACE || c == idtnl_pkg::CH_TAB) return 1'b0;
        // newline before any name character: empty name
        if (c == idtnl_pkg::CH_NEWLINE) return finish_search(miss_status(), res);
        scan_phase = SCAN_NAME;
        if (line_type == idtnl_pkg::LINE_VENDOR) vendor_hit = 1'b1;
        res = '{kind: char_kind(), name_char: c, status: idtnl_pkg::STATUS_BOTH_FOUND};
        return 1'b1;
      end
      SCAN_NAME: begin
        if (c == idtnl_pkg::CH_NEWLINE) begin
          if (line_type == idtnl_pkg::LINE_VENDOR) begin
            scan_phase = SCAN_LINE_START;
            return 1'b0;
          end
          return finish_search(idtnl_pkg::STATUS_BOTH_FOUND, res);
        end
        res = '{kind: char_kind(), name_char: c, status: idtnl_pkg::STATUS_BOTH_FOUND};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // watch config writes, results and requests on each edge
  always @(posedge clk) begin
    idtnl_pkg::result_t want;
    idtnl_pkg::result_t got;
    idtnl_pkg::result_t res;
    if (rst) begin
      clear_scan();
      want_vendor  = '0;
      want_product = '0;
      pending_name_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == VENDOR_ADDR) want_vendor = pwdata[idtnl_pkg::ID_W-1:0];
        else if (paddr == PRODUCT_ADDR) want_product = pwdata[idtnl_pkg::ID_W-1:0];
      end
      // results are registered after their request is accepted, so compare before predicting
      if (result_valid && result_ready) begin
        got = result;
        if (pending_name_results.size() == 0) begin
          $error("result with no expectation waiting: kind %0d name_char %02h status %0d",
                 got.kind, got.name_char, got.status);
          mismatches++;
        end else begin
          want = pending_name_results.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            mismatches++;
          end
          if (got.name_char !== want.name_char) begin
            $error("name_char: expected %02h, actual %02h", want.name_char, got.name_char);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
          end
        end
      end
      if (item_valid && item_ready) begin
        if (scan_table_byte(item, res)) pending_name_results.push_back(res);
      end
    end
    pending_count <= pending_name_results.size();
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the id table name lookup: table stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb;

  localparam int ID_DIGITS   = idtnl_pkg::ID_DIGITS_DEFAULT;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 60;

  localparam logic [idtnl_pkg::CFG_ADDR_W-1:0] VENDOR_ADDR  =
    {idtnl_pkg::REG_VENDOR_ID, 2'b00};
  localparam logic [idtnl_pkg::CFG_ADDR_W-1:0] PRODUCT_ADDR =
    {idtnl_pkg::REG_PRODUCT_ID, 2'b00};

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  logic                             clk;
  logic                             rst;
  logic                             item_valid;
  logic                             item_ready;
  idtnl_pkg::item_t                 item;
  logic                             result_valid;
  logic                             result_ready;
  idtnl_pkg::result_t               result;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [idtnl_pkg::CFG_ADDR_W-1:0] paddr;
  logic [idtnl_pkg::CFG_DATA_W-1:0] pwdata;
  logic [idtnl_pkg::CFG_DATA_W-1:0] prdata;
  logic                             pready;

  int error_count;
  int pending_count;
  int cycle_count;
  int items_sent;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  bit hold_served;

  logic [idtnl_pkg::ID_W-1:0] cur_vendor;
  logic [idtnl_pkg::ID_W-1:0] cur_product;
  idtnl_pkg::item_t           text_q[$];

  id_table_name_lookup_stream_core #(.ID_DIGITS(ID_DIGITS)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  name_lookup_checker #(.ID_DIGITS(ID_DIGITS)) lookup_check (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .error_count(error_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    result_ready = 1'b0;
    hold_served  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        result_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served = 1'b1;
      end
      result_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---- table text building ----
  task automatic push_char(input logic [7:0] c);
    text_q.push_back('{byte_value: c, end_of_file: 1'b0});
  endtask

  task automatic push_eof();
    text_q.push_back('{byte_value: 8'($urandom_range(255)), end_of_file: 1'b1});
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input int n);
    if (n < 10) return CH_ZERO + 8'(n);
    return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(n - 10);
  endfunction

  task automatic push_hex_id(input logic [31:0] id);
    for (int i = ID_DIGITS - 1; i >= 0; i--) push_char(hex_char(int'((id >> (4 * i)) & 4'hF)));
  endtask

  function automatic logic [7:0] name_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == idtnl_pkg::CH_NEWLINE);
    return c;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0: return hex_char($urandom_range(15));
      1: return idtnl_pkg::CH_NEWLINE;
      2: return idtnl_pkg::CH_TAB;
      3: return idtnl_pkg::CH_SPACE;
      4: return idtnl_pkg::CH_HASH;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // leading blanks, then the name
  task automatic push_name(input int len);
    repeat ($urandom_range(2)) push_char($urandom_range(1) ? idtnl_pkg::CH_SPACE
                                                           : idtnl_pkg::CH_TAB);
    repeat (len) push_char(name_byte());
  endtask

  function automatic int name_len();
    return ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
  endfunction

  task automatic push_line(input logic [1:0] kind, input logic [31:0] id, input int len);
    if (kind != idtnl_pkg::LINE_VENDOR) push_char(idtnl_pkg::CH_TAB);
    if (kind == idtnl_pkg::LINE_INTERFACE) push_char(idtnl_pkg::CH_TAB);
    push_hex_id(id);
    push_name(len);
    push_char(idtnl_pkg::CH_NEWLINE);
  endtask

  // comment or blank line now and then
  task automatic push_filler();
    case ($urandom_range(9))
      0, 1, 2: begin
        push_char(idtnl_pkg::CH_HASH);
        push_name($urandom_range(5));
        push_char(idtnl_pkg::CH_NEWLINE);
      end
      3, 4: push_char(idtnl_pkg::CH_NEWLINE);
      default: ;
    endcase
  endtask

  task automatic push_products(input logic [idtnl_pkg::ID_W-1:0] target, input bit matched);
    repeat ($urandom_range(2)) begin
      push_filler();
      if ($urandom_range(3) == 0 || target == 0)
        push_line(idtnl_pkg::LINE_INTERFACE, $urandom_range(16'hFFFF), name_len());
      else
        push_line(idtnl_pkg::LINE_PRODUCT, $urandom_range(target - 1, 0), name_len());
    end
    if (matched) begin
      if ($urandom_range(99) < 70) push_line(idtnl_pkg::LINE_PRODUCT, target, name_len());
      if ($urandom_range(1) && target < 16'hFFFF)
        push_line(idtnl_pkg::LINE_PRODUCT, $urandom_range(16'hFFFF, target + 1), name_len());
    end
  endtask

  // mostly well-formed tables around the wanted ids, some noise and damage
  task automatic build_table(input logic [idtnl_pkg::ID_W-1:0] vendor,
                             input logic [idtnl_pkg::ID_W-1:0] product);
    int idx;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(8, 30)) push_char(noise_byte());
    end else begin
      repeat ($urandom_range(2)) begin
        push_filler();
        if (vendor > 0) begin
          push_line(idtnl_pkg::LINE_VENDOR, $urandom_range(vendor - 1, 0), name_len());
          push_products(16'($urandom_range(16'hFFFF)), 1'b0);
        end
      end
      if ($urandom_range(99) < 75) begin
        push_line(idtnl_pkg::LINE_VENDOR, vendor, name_len());
        push_products(product, 1'b1);
      end
      if ($urandom_range(1) && vendor < 16'hFFFF) begin
        push_filler();
        push_line(idtnl_pkg::LINE_VENDOR, $urandom_range(16'hFFFF, vendor + 1), name_len());
        push_products(16'($urandom_range(16'hFFFF)), 1'b0);
      end
      if ($urandom_range(99) < 15 && text_q.size() > 0) begin
        idx = $urandom_range(text_q.size() - 1);
        text_q[idx].byte_value = noise_byte();
      end
      if ($urandom_range(99) < 10 && text_q.size() > 1) begin
        idx = $urandom_range(text_q.size() - 1);
        while (text_q.size() > idx) void'(text_q.pop_back());
      end
    end
    push_eof();
  endtask

  // ---- drivers; every task starts and ends at a falling edge ----
  task automatic send_item(input idtnl_pkg::item_t it);
    // idle cycle by cycle at the set rate
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item       = it;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text();
    while (text_q.size() > 0) send_item(text_q.pop_front());
  endtask

  task automatic wait_idle();
    item_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [idtnl_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [idtnl_pkg::ID_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = idtnl_pkg::CFG_DATA_W'(data);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_ids(input logic [idtnl_pkg::ID_W-1:0] vendor,
                         input logic [idtnl_pkg::ID_W-1:0] product);
    wait_idle();
    cfg_write(VENDOR_ADDR, vendor);
    cfg_write(PRODUCT_ADDR, product);
    cur_vendor  = vendor;
    cur_product = product;
  endtask

  function automatic logic [idtnl_pkg::ID_W-1:0] pick_id();
    case ($urandom_range(5))
      0: return '0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // ---- stimulus ----
  initial begin
    int stop_at;
    rst            = 1'b1;
    item_valid     = 1'b0;
    item           = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    items_sent     = 0;
    send_idle_pct  = 19;
    recv_stall_pct = 59;
    hold_request   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // both found, comments, blanks, interface line, high-bit name byte
    set_ids(16'h0000, 16'h0000);
    push_str("#c\n\n0000 \tA");
    push_char(8'hFF);
    push_str("\n\t\t0000 i\n\t0000B\n");
    push_eof();
    send_text();
    // empty name at the top id; bytes after finish are ignored
    set_ids(16'hFFFF, 16'hFFFF);
    push_str("fFfF\n9");
    push_eof();
    send_text();
    set_ids(16'h00A5, 16'h0010);
    push_str("00g");            // bad digit
    push_eof();
    push_str("0100 z\n");       // larger vendor id
    push_eof();
    push_str("00a5 v\n\t#");    // hash where a product digit is due
    push_eof();
    push_str("00A5 v\n\t0011 p\n");  // larger product id
    push_eof();
    push_str("00a5 v\n0100");   // next vendor line ends the product search
    push_eof();
    push_str("00a5 v\n\t0010 pq");   // end of table inside the product name
    push_eof();
    push_str("00a5 vw");        // end of table inside the vendor name
    push_eof();
    push_eof();                 // end of table with nothing read
    send_text();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 19; recv_stall_pct = 59; end
        1: begin send_idle_pct = 59; recv_stall_pct = 19; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (mode == 2) begin
        // long receiver hold-off against a long matching name
        set_ids(pick_id(), pick_id());
        hold_request = 1'b1;
        push_hex_id(cur_vendor);
        push_char(idtnl_pkg::CH_SPACE);
        push_name(24);
        push_char(idtnl_pkg::CH_NEWLINE);
        push_eof();
        send_text();
      end
      stop_at = items_sent + 70;
      while (items_sent < stop_at) begin
        if ($urandom_range(1)) set_ids(pick_id(), pick_id());
        build_table(cur_vendor, cur_product);
        send_text();
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
